// ===== hw/rtl/greedy_iou_track_table_macros.svh =====
// ----------------------------------------------------------------------------
// track table assertion macros
// shared assertion forms for the tracker rtl
// ----------------------------------------------------------------------------
`ifndef GREEDY_IOU_TRACK_TABLE_MACROS_SVH
`define GREEDY_IOU_TRACK_TABLE_MACROS_SVH

// implication checked every cycle outside reset
`define GITT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define GITT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/gitt_pkg.sv =====
// ----------------------------------------------------------------------------
// gitt_pkg
// types and constants of the iou track table
// ----------------------------------------------------------------------------
package gitt_pkg;

  localparam int MAX_TRACKS_DEF = 32;
  localparam int COORD_BITS_DEF = 12;
  localparam int FIELD_BITS     = 12;
  localparam int COLOR_COUNT    = 30;

  localparam logic [0:0] REG_IOU_PERCENT = 1'd0;
  localparam logic [0:0] REG_MISS_LIMIT  = 1'd1;

  localparam logic FUNC_BOX = 1'b0;
  localparam logic FUNC_EOF = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [FIELD_BITS-1:0] left_x;
    logic [FIELD_BITS-1:0] top_y;
    logic [FIELD_BITS-1:0] right_x;
    logic [FIELD_BITS-1:0] bottom_y;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  track_slot;
    logic [4:0]  color_index;
    logic [15:0] age_frames;
    logic        new_track;
    logic        table_full;
    logic        frame_end;
    logic [5:0]  live_tracks;
  } out_word_t;

  // command for the cells of the chain, applied by the tail cell
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_UPDATE,
    CMD_OPEN,
    CMD_AGE
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  miss_limit;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/greedy_iou_track_table.sv =====
// ----------------------------------------------------------------------------
// greedy_iou_track_table
// greedy iou multi object track table built as a rotating chain of slot cells
// ----------------------------------------------------------------------------
//  channel  signals                                    direction
//  in       start, in_word (busy goes out)             into block
//  out      out_strobe, out_word                       out of block
//  cfg      cfg_valid, cfg_index, cfg_data (cfg_ready goes out) into block
//
//  a box that opens a track scores every slot through the 3-stage iou pipe,
//  passes the threshold multiply and decide states, takes one rotation to find
//  a free slot and one to write, then finishes in the done state. a matched box
//  skips the free-slot rotation; a full table skips the write rotation.
//  end of frame is one rotation with aging.
//  the result word follows in the first idle cycle;
//  the result receiver cannot stall.
`include "greedy_iou_track_table_macros.svh"

module greedy_iou_track_table #(
  parameter int MAX_TRACKS = gitt_pkg::MAX_TRACKS_DEF,
  parameter int COORD_BITS = gitt_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  gitt_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output gitt_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import gitt_pkg::*;

  localparam int SW = $clog2(MAX_TRACKS);
  localparam int CW = $clog2(MAX_TRACKS + 1);
  localparam int CB = COORD_BITS;
  localparam int PD = 3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCORE, S_DECIDE, S_FREE, S_WRITE, S_AGE, S_MULT, S_DONE
  } state_t;

  state_t state;
  logic [6:0] iou_percent;
  logic [7:0] miss_limit;
  logic [4*CB-1:0] box_q;
  logic [CW:0] cnt;
  logic [SW-1:0] pos;      // slot number of the cell at chain head
  logic [SW-1:0] tgt;
  logic          found;
  logic [2*CB-1:0] best_i;
  logic [2*CB:0]   best_u;
  logic [SW-1:0]   best_s;
  logic            best_ok;
  logic [SW-1:0]   spos [PD];
  logic [4:0]      next_color;
  logic [CW-1:0]   live;
  logic            shift, upd;
  cell_ctl_t       ctl;

  logic [4*CB-1:0] c_box     [MAX_TRACKS];
  logic [15:0]     c_age     [MAX_TRACKS];
  logic [7:0]      c_missed  [MAX_TRACKS];
  logic [4:0]      c_color   [MAX_TRACKS];
  logic            c_valid   [MAX_TRACKS];
  logic            c_before  [MAX_TRACKS];
  logic            c_matched [MAX_TRACKS];

  // cell 0 is the head; it feeds the last cell, rotating the ring
  for (genvar g = 0; g < MAX_TRACKS; g++) begin : g_cell
    localparam int N = (g + 1) % MAX_TRACKS;
    gitt_cell #(.CB(CB)) u_cell (
      .clk(clk), .rst(rst), .shift(shift),
      .upd(upd && (g == MAX_TRACKS - 1)), .ctl(ctl),
      .box_in(box_q), .color_in(next_color),
      .in_box(c_box[N]), .in_age(c_age[N]), .in_missed(c_missed[N]),
      .in_color(c_color[N]), .in_valid(c_valid[N]), .in_before(c_before[N]),
      .in_matched(c_matched[N]),
      .box(c_box[g]), .age(c_age[g]), .missed(c_missed[g]), .color(c_color[g]),
      .valid(c_valid[g]), .prior(c_before[g]), .matched(c_matched[g])
    );
  end

  // update hits the cell moving out of head into the tail
  logic upd_hit;
  assign upd_hit = (pos == tgt);

  logic [2*CB-1:0] s_inter;
  logic [2*CB:0]   s_uni;
  logic            s_ok;
  gitt_iou #(.CB(CB)) u_iou (
    .clk(clk), .a(box_q), .b(c_box[0]),
    .eligible(c_valid[0] && c_before[0] && !c_matched[0]),
    .inter(s_inter), .uni(s_uni), .ok(s_ok)
  );

  // cross products for best compare, formed combinationally
  logic [4*CB+1:0] lhs, rhs;
  logic            cmp_gt;
  assign lhs = (4*CB+2)'(s_inter) * (4*CB+2)'(best_u);
  assign rhs = (4*CB+2)'(best_i) * (4*CB+2)'(s_uni);
  assign cmp_gt = lhs > rhs;

  logic [2*CB+7:0] t_lhs, t_rhs;
  logic            thr_ok;
  assign thr_ok = best_ok && (t_lhs >= t_rhs);

  logic [SW-1:0] pos_inc;
  assign pos_inc = (pos == SW'(MAX_TRACKS - 1)) ? '0 : pos + SW'(1);

  // scoring rotates exactly one turn so every pass starts at slot 0
  always_comb begin
    shift   = ((state == S_SCORE) && (cnt < (CW+1)'(MAX_TRACKS))) || (state == S_FREE)
              || (state == S_WRITE) || (state == S_AGE);
    ctl.miss_limit = miss_limit;
    ctl.cmd = CMD_NONE;
    upd = 1'b0;
    if (state == S_WRITE && upd_hit) begin
      upd = 1'b1;
      ctl.cmd = best_ok ? CMD_UPDATE : CMD_OPEN;
    end else if (state == S_AGE) begin
      upd = 1'b1;
      ctl.cmd = CMD_AGE;
    end
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iou_percent <= 7'd45;
      miss_limit <= 8'd5;
      next_color <= '0;
      pos <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (state == S_DONE);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_IOU_PERCENT: iou_percent <= cfg_data[6:0];
          REG_MISS_LIMIT:  miss_limit <= cfg_data;
          default: ;
        endcase
      end
      if (shift) pos <= pos_inc;
      spos[0] <= pos;
      for (int k = 1; k < PD; k++) spos[k] <= spos[k-1];
      unique case (state)
        S_IDLE: begin
          if (start) begin
            box_q <= {CB'(in_word.left_x), CB'(in_word.top_y),
                      CB'(in_word.right_x), CB'(in_word.bottom_y)};
            cnt <= '0;
            live <= '0;
            best_i <= '0;
            best_u <= (2*CB+1)'(1);
            best_ok <= 1'b0;
            found <= 1'b0;
            out_word <= '0;
            state <= (in_word.func == FUNC_EOF) ? S_AGE : S_SCORE;
          end
        end
        S_SCORE: begin
          cnt <= cnt + (CW+1)'(1);
          if (cnt >= (CW+1)'(PD) && s_ok && cmp_gt) begin
            best_i <= s_inter;
            best_u <= s_uni;
            best_s <= spos[PD-1];
            best_ok <= 1'b1;
          end
          if (cnt == (CW+1)'(MAX_TRACKS + PD - 1)) state <= S_MULT;
        end
        S_MULT: begin
          t_lhs <= (2*CB+8)'(best_i) * (2*CB+8)'(100);
          t_rhs <= (2*CB+8)'(best_u) * (2*CB+8)'(iou_percent);
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          best_ok <= thr_ok;
          cnt <= '0;
          if (thr_ok) begin
            tgt <= best_s;
            state <= S_WRITE;
          end else begin
            state <= S_FREE;
          end
        end
        S_FREE: begin
          cnt <= (cnt == (CW+1)'(MAX_TRACKS - 1)) ? '0 : cnt + (CW+1)'(1);
          if (!found && !c_valid[0]) begin
            found <= 1'b1;
            tgt <= pos;
          end
          if (cnt == (CW+1)'(MAX_TRACKS - 1)) begin
            if (found || !c_valid[0]) begin
              state <= S_WRITE;
            end else begin
              out_word.table_full <= 1'b1;
              state <= S_DONE;
            end
          end
        end
        S_WRITE: begin
          cnt <= cnt + (CW+1)'(1);
          if (upd_hit) begin
            out_word.track_slot <= 5'(tgt);
            out_word.color_index <= best_ok ? c_color[0] : next_color;
            out_word.age_frames <= best_ok ?
              ((c_age[0] == 16'hFFFF) ? c_age[0] : c_age[0] + 16'd1) : 16'd1;
            out_word.new_track <= !best_ok;
            if (!best_ok)
              next_color <= (next_color == 5'(COLOR_COUNT - 1)) ? '0 : next_color + 5'd1;
          end
          if (cnt == (CW+1)'(MAX_TRACKS - 1)) state <= S_DONE;
        end
        S_AGE: begin
          cnt <= cnt + (CW+1)'(1);
          if (c_valid[0] && !(c_before[0] && !c_matched[0] &&
              (((c_missed[0] == 8'hFF) ? c_missed[0] : c_missed[0] + 8'd1) > miss_limit)))
            live <= live + CW'(1);
          if (cnt == (CW+1)'(MAX_TRACKS - 1)) begin
            out_word.frame_end <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          out_word.live_tracks <= out_word.frame_end ? 6'(live) : 6'd0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GITT_ASSERT_IMP(a_no_cfg_busy, clk, rst, busy, !cfg_ready)
  `GITT_ASSERT_IMP(a_strobe_idle, clk, rst, out_strobe, !busy)
  `GITT_ASSERT_IMP(a_full_empty, clk, rst, out_strobe && out_word.table_full,
    !out_word.new_track && out_word.age_frames == 16'd0)

endmodule

// ===== hw/rtl/gitt_cell.sv =====
// ----------------------------------------------------------------------------
// gitt_cell
// one track slot; shifts its record to the neighbor during a scan
// ----------------------------------------------------------------------------
module gitt_cell #(
  parameter int CB = gitt_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  logic                 upd,
  input  gitt_pkg::cell_ctl_t  ctl,
  input  logic [4*CB-1:0]      box_in,
  input  logic [4*CB-1:0]      in_box,
  input  logic [15:0]          in_age,
  input  logic [7:0]           in_missed,
  input  logic [4:0]           in_color,
  input  logic                 in_valid,
  input  logic                 in_before,
  input  logic                 in_matched,
  input  logic [4:0]           color_in,
  output logic [4*CB-1:0]      box,
  output logic [15:0]          age,
  output logic [7:0]           missed,
  output logic [4:0]           color,
  output logic                 valid,
  output logic                 prior,
  output logic                 matched
);
  import gitt_pkg::*;

  logic [7:0]  miss_inc;
  logic [15:0] age_inc;

  always_comb begin
    miss_inc = (in_missed == 8'hFF) ? in_missed : in_missed + 8'd1;
    age_inc  = (in_age == 16'hFFFF) ? in_age : in_age + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      box    <= in_box;
      age    <= in_age;
      missed <= in_missed;
      color  <= in_color;
      if (upd) begin
        unique case (ctl.cmd)
          CMD_UPDATE: begin
            box    <= box_in;
            age    <= age_inc;
            missed <= 8'd0;
          end
          CMD_OPEN: begin
            box    <= box_in;
            age    <= 16'd1;
            missed <= 8'd0;
            color  <= color_in;
          end
          CMD_AGE: begin
            if (in_valid && in_before && !in_matched) begin
              missed <= miss_inc;
              age    <= age_inc;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      prior   <= 1'b0;
      matched <= 1'b0;
    end else if (shift) begin
      valid   <= in_valid;
      prior   <= in_before;
      matched <= in_matched;
      if (upd) begin
        unique case (ctl.cmd)
          CMD_UPDATE: matched <= 1'b1;
          CMD_OPEN: begin
            valid   <= 1'b1;
            prior   <= 1'b0;
            matched <= 1'b1;
          end
          CMD_AGE: begin
            if (in_valid && in_before && !in_matched && (miss_inc > ctl.miss_limit)) begin
              valid <= 1'b0;
              prior <= 1'b0;
            end else begin
              prior <= in_valid;
            end
            matched <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/gitt_iou.sv =====
// ----------------------------------------------------------------------------
// gitt_iou
// pipelined iou scoring of the box against the slot at the chain head
// ----------------------------------------------------------------------------
module gitt_iou #(
  parameter int CB = gitt_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic [4*CB-1:0]   a,
  input  logic [4*CB-1:0]   b,
  input  logic              eligible,
  output logic [2*CB-1:0]   inter,
  output logic [2*CB:0]     uni,
  output logic              ok
);
  logic [CB-1:0] al, at, ar, ab, bl, bt, br, bb;
  logic [CB-1:0] il, it, ir, ib;
  logic [CB-1:0] wa, ha, wb, hb, wi, hi;
  logic [CB-1:0] wa_q, ha_q, wb_q, hb_q, wi_q, hi_q;
  logic          el_q, el_q2;
  logic [2*CB-1:0] area_a, area_b, area_i;

  function automatic logic [CB-1:0] span(input logic [CB-1:0] lo_v, input logic [CB-1:0] hi_v);
    span = (hi_v > lo_v) ? hi_v - lo_v : '0;
  endfunction

  always_comb begin
    {al, at, ar, ab} = a;
    {bl, bt, br, bb} = b;
    il = (al > bl) ? al : bl;
    it = (at > bt) ? at : bt;
    ir = (ar < br) ? ar : br;
    ib = (ab < bb) ? ab : bb;
    wa = span(al, ar);
    ha = span(at, ab);
    wb = span(bl, br);
    hb = span(bt, bb);
    wi = span(il, ir);
    hi = span(it, ib);
  end

  always_ff @(posedge clk) begin
    wa_q <= wa;
    ha_q <= ha;
    wb_q <= wb;
    hb_q <= hb;
    wi_q <= wi;
    hi_q <= hi;
    el_q <= eligible;
    area_a <= (2*CB)'(wa_q) * (2*CB)'(ha_q);
    area_b <= (2*CB)'(wb_q) * (2*CB)'(hb_q);
    area_i <= (2*CB)'(wi_q) * (2*CB)'(hi_q);
    el_q2  <= el_q;
    inter  <= area_i;
    uni    <= {1'b0, area_a} + {1'b0, area_b} - {1'b0, area_i};
    ok     <= el_q2 && (({1'b0, area_a} + {1'b0, area_b} - {1'b0, area_i}) != '0);
  end

endmodule
